// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RC4_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define RC4_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define RC4_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RC4_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// types and constants shared by the rc4 sequencer and datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int BYTE_W     = 8;
   localparam int PERM_DEPTH = 256;
   localparam int PERM_AW    = 8;
   localparam int KEY_MAX    = 16;
   localparam int KEY_IDX_W  = 4;
   localparam int KEY_REG_W  = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int UPC_W      = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

   typedef logic [UPC_W-1:0] upc_type;

   // microcode step addresses
   localparam upc_type UPC_FILL     = 4'd0;
   localparam upc_type UPC_FILL_END = 4'd1;
   localparam upc_type UPC_KA       = 4'd2;
   localparam upc_type UPC_KB       = 4'd3;
   localparam upc_type UPC_KC       = 4'd4;
   localparam upc_type UPC_KD       = 4'd5;
   localparam upc_type UPC_KEND     = 4'd6;
   localparam upc_type UPC_P0       = 4'd7;
   localparam upc_type UPC_P1       = 4'd8;
   localparam upc_type UPC_P2       = 4'd9;
   localparam upc_type UPC_P3       = 4'd10;
   localparam upc_type UPC_P4       = 4'd11;
   localparam upc_type UPC_DISPATCH = 4'd12;

   typedef enum logic [1:0] {
      ADDR_K,
      ADDR_J_NEXT,
      ADDR_I_NEXT,
      ADDR_T
   } addr_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_FILL,
      WR_K_RD,
      WR_I_RD,
      WR_J_SI
   } wr_sel_type;

   typedef enum logic [1:0] {
      J_HOLD,
      J_CLEAR,
      J_KSA,
      J_PRGA
   } j_op_type;

   typedef enum logic [1:0] {
      I_HOLD,
      I_CLEAR,
      I_INC
   } i_op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_K_NOT_LAST,
      COND_KS_IDLE,
      COND_OUT_BUSY,
      COND_DISPATCH
   } cond_type;

   // one control word of the microprogram
   typedef struct packed {
      addr_sel_type addr_sel;
      wr_sel_type   wr_sel;
      j_op_type     j_op;
      i_op_type     i_op;
      logic         si_ld;
      logic         sj_ld;
      logic         k_inc;
      logic         kc_inc;
      logic         ks_clr;
      logic         emit;
      logic         take;
      cond_type     cond;
      upc_type      target;
   } ctrl_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic accept;
      logic first;
      logic k_last;
      logic ks;
      logic out_busy;
   } status_type;

endpackage

// File: sv/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/rc4_useq.sv
// ----------------------------------------------------------------------------
// rc4_useq
// microprogram rom, step counter and jump logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rc4_useq (
   input  logic                clock,
   input  logic                reset,
   input  rc4_pkg::status_type status,
   output rc4_pkg::ctrl_type   ctrl
);

   import rc4_pkg::*;

   upc_type upc_ff;
   upc_type upc_in;

   function automatic ctrl_type ucode_word(input upc_type step);
      ctrl_type w;
      w = '0;
      unique case (step)
         UPC_FILL: begin
            w.wr_sel = WR_FILL;
            w.k_inc  = 1'b1;
            w.cond   = COND_K_NOT_LAST;
            w.target = UPC_FILL;
         end
         UPC_FILL_END: begin
            w.cond   = COND_KS_IDLE;
            w.target = UPC_DISPATCH;
         end
         UPC_KA: begin
            w.addr_sel = ADDR_K;
         end
         UPC_KB: begin
            w.si_ld    = 1'b1;
            w.j_op     = J_KSA;
            w.addr_sel = ADDR_J_NEXT;
         end
         UPC_KC: begin
            w.wr_sel = WR_K_RD;
         end
         UPC_KD: begin
            w.wr_sel = WR_J_SI;
            w.k_inc  = 1'b1;
            w.kc_inc = 1'b1;
            w.cond   = COND_K_NOT_LAST;
            w.target = UPC_KA;
         end
         UPC_KEND: begin
            w.i_op   = I_CLEAR;
            w.j_op   = J_CLEAR;
            w.ks_clr = 1'b1;
         end
         UPC_P0: begin
            w.i_op     = I_INC;
            w.addr_sel = ADDR_I_NEXT;
         end
         UPC_P1: begin
            w.si_ld    = 1'b1;
            w.j_op     = J_PRGA;
            w.addr_sel = ADDR_J_NEXT;
         end
         UPC_P2: begin
            w.sj_ld  = 1'b1;
            w.wr_sel = WR_I_RD;
         end
         UPC_P3: begin
            w.wr_sel   = WR_J_SI;
            w.addr_sel = ADDR_T;
         end
         UPC_P4: begin
            w.addr_sel = ADDR_T;
            w.emit     = 1'b1;
            w.cond     = COND_OUT_BUSY;
            w.target   = UPC_P4;
         end
         UPC_DISPATCH: begin
            w.take     = 1'b1;
            w.addr_sel = ADDR_I_NEXT;
            w.cond     = COND_DISPATCH;
            w.target   = UPC_P1;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = UPC_DISPATCH;
         end
      endcase
      return w;
   endfunction

   assign ctrl = ucode_word(upc_ff);

   always_comb begin
      upc_in = upc_ff + 1'b1;
      unique case (ctrl.cond)
         COND_NONE:       upc_in = upc_ff + 1'b1;
         COND_ALWAYS:     upc_in = ctrl.target;
         COND_K_NOT_LAST: upc_in = status.k_last ? upc_ff + 1'b1 : ctrl.target;
         COND_KS_IDLE:    upc_in = status.ks ? upc_ff + 1'b1 : ctrl.target;
         COND_OUT_BUSY:   upc_in = status.out_busy ? ctrl.target : upc_ff + 1'b1;
         COND_DISPATCH: begin
            priority if (!status.accept) upc_in = upc_ff;
            else if (status.first)       upc_in = UPC_FILL;
            else                         upc_in = ctrl.target;
         end
         default:         upc_in = UPC_DISPATCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_FILL;
      end else begin
         upc_ff <= upc_in;
      end
   end

   `RC4_ASSERT_NEXT(a_first_goes_fill, clock, reset, status.accept && status.first, upc_ff == UPC_FILL)
   `RC4_ASSERT_NEXT(a_busy_holds_step, clock, reset, (ctrl.cond == COND_OUT_BUSY) && status.out_busy, upc_ff == $past(upc_ff))
   `RC4_ASSERT_IMPL(a_step_in_program, clock, reset, 1'b1, upc_ff <= UPC_DISPATCH)

endmodule

// File: sv/rc4_dp.sv
// ----------------------------------------------------------------------------
// rc4_dp
// rc4 datapath: indices, swap registers, key registers, permutation ram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rc4_dp #(
   parameter int KEY_BYTES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rc4_pkg::ctrl_type                   ctrl,
   output rc4_pkg::status_type                 status,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rc4_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic                                req_first,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rc4_pkg::BYTE_W-1:0]          rsp_cipher_byte,
   input  logic                                csr_we,
   input  logic [rc4_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rc4_pkg::KEY_REG_W-1:0]       csr_wdata
);

   import rc4_pkg::*;

   logic [BYTE_W-1:0]    i_ff, i_in;
   logic [BYTE_W-1:0]    j_ff, j_in;
   logic [PERM_AW-1:0]   k_ff, k_in;
   logic [KEY_IDX_W-1:0] kc_ff, kc_in;
   logic                 ks_ff, ks_in;
   logic [BYTE_W-1:0]    si_ff, sj_ff, data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    rsp_cipher_byte_ff;
   logic [KEY_REG_W-1:0] key_low_ff, key_high_ff;

   logic [KEY_MAX-1:0][BYTE_W-1:0] key_bytes;
   logic [BYTE_W-1:0]  key_byte;
   logic [BYTE_W-1:0]  i_next, t_addr, z_byte;
   logic               accept, out_busy, load_rsp;

   logic               ram_we;
   logic [PERM_AW-1:0] ram_waddr, ram_raddr;
   logic [BYTE_W-1:0]  ram_wdata, ram_rdata;

   assign accept    = req_valid && ctrl.take;
   assign req_stall = !ctrl.take;
   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign load_rsp  = ctrl.emit && !out_busy;

   assign key_bytes = {key_high_ff, key_low_ff};
   assign key_byte  = key_bytes[kc_ff];
   assign i_next    = i_ff + 1'b1;
   assign t_addr    = si_ff + sj_ff;
   // a read of S[j] races the swap write, so take the swapped-in value
   assign z_byte    = (t_addr == j_ff) ? si_ff : ram_rdata;

   assign status = '{accept:   accept,
                     first:    req_first,
                     k_last:   (k_ff == PERM_AW'(PERM_DEPTH - 1)),
                     ks:       ks_ff,
                     out_busy: out_busy};

   always_comb begin
      priority if (accept && req_first) begin
         j_in = '0;
      end else begin
         unique case (ctrl.j_op)
            J_HOLD:  j_in = j_ff;
            J_CLEAR: j_in = '0;
            J_KSA:   j_in = j_ff + ram_rdata + key_byte;
            J_PRGA:  j_in = j_ff + ram_rdata;
            default: j_in = j_ff;
         endcase
      end
   end

   always_comb begin
      priority if (accept && !req_first) begin
         i_in = i_next;
      end else begin
         unique case (ctrl.i_op)
            I_HOLD:  i_in = i_ff;
            I_CLEAR: i_in = '0;
            I_INC:   i_in = i_next;
            default: i_in = i_ff;
         endcase
      end
   end

   always_comb begin
      k_in  = ctrl.k_inc ? k_ff + 1'b1 : k_ff;
      kc_in = kc_ff;
      if (ctrl.kc_inc) begin
         kc_in = (kc_ff == KEY_IDX_W'(KEY_BYTES - 1)) ? '0 : kc_ff + 1'b1;
      end
      ks_in = ctrl.ks_clr ? 1'b0 : ks_ff;
      if (accept && req_first) begin
         k_in  = '0;
         kc_in = '0;
         ks_in = 1'b1;
      end
   end

   always_comb begin
      unique case (ctrl.addr_sel)
         ADDR_K:      ram_raddr = k_ff;
         ADDR_J_NEXT: ram_raddr = j_in;
         ADDR_I_NEXT: ram_raddr = i_next;
         ADDR_T:      ram_raddr = t_addr;
         default:     ram_raddr = k_ff;
      endcase
   end

   always_comb begin
      ram_we    = 1'b1;
      ram_waddr = k_ff;
      ram_wdata = '0;
      unique case (ctrl.wr_sel)
         WR_NONE: ram_we = 1'b0;
         WR_FILL: begin
            ram_waddr = k_ff;
            ram_wdata = k_ff;
         end
         WR_K_RD: begin
            ram_waddr = k_ff;
            ram_wdata = ram_rdata;
         end
         WR_I_RD: begin
            ram_waddr = i_ff;
            ram_wdata = ram_rdata;
         end
         WR_J_SI: begin
            ram_waddr = j_ff;
            ram_wdata = si_ff;
         end
         default: ram_we = 1'b0;
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         kc_ff        <= '0;
         ks_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
      end else begin
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         kc_ff        <= kc_in;
         ks_ff        <= ks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == REG_KEY_LOW)) begin
            key_low_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == REG_KEY_HIGH)) begin
            key_high_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.si_ld) begin
         si_ff <= ram_rdata;
      end
      if (ctrl.sj_ld) begin
         sj_ff <= ram_rdata;
      end
      if (accept) begin
         data_ff <= req_data_byte;
      end
      if (load_rsp) begin
         rsp_cipher_byte_ff <= data_ff ^ z_byte;
      end
   end

   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PERM_DEPTH)
   ) u_perm_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_byte = rsp_cipher_byte_ff;

   `RC4_ASSERT_IMPL(a_no_write_on_take, clock, reset, ctrl.take, !ram_we)
   `RC4_ASSERT_NEXT(a_emit_sets_valid, clock, reset, load_rsp, rsp_valid_ff)
   `RC4_ASSERT_IMPL(a_schedule_wraps_k, clock, reset, ctrl.ks_clr, k_ff == '0)

endmodule

// File: sv/rc4_keystream_xor_top.sv
// a plain item is taken at dispatch; steps P1 to P4 load its byte to rsp, then the next item is taken
// an item with first set first refills and reschedules the permutation before its byte is made
// byte rate is set by the one-write one-read permutation ram: three reads and two writes per byte
// reset is synchronous: indices and keys clear, then a fill pass writes the identity
// permutation into the ram while req_stall stays high (csr writes are taken as ever)
// ----------------------------------------------------------------------------
// rc4_keystream_xor_top
// rc4 stream cipher, one data item in and one xored item out per byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_keystream_xor_top #(
   parameter int KEY_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_cipher_byte,
   // key registers
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   import rc4_pkg::*;

   // control word of the current step and datapath flags fed back for jumps
   ctrl_type   ctrl;
   status_type status;

   // sequencer: fill loop, key schedule loop, per-byte generator steps and
   // the dispatch step that is the only place an item is taken
   rc4_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // datapath: i, j, swap registers, key select and the permutation ram;
   // the output register lets the next item in while a result waits
   rc4_dp #(
      .KEY_BYTES (KEY_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_first       (req_first),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cipher_byte (rsp_cipher_byte),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

endmodule
